FILE: hw/rtl/pmfb_pkg.sv
// Shared types, constants and helpers for the paged monochrome frame buffer.
// Used by the front end, the request queue, the back end and the top level.
package pmfb_pkg;

  // Default geometry: 128 columns by 8 pages of 8 pixel rows.
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // Depth of the queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  // Command codes carried on the input channel.
  localparam logic [2:0] CMD_PIXEL     = 3'd0;
  localparam logic [2:0] CMD_WRITE_XY  = 3'd1;
  localparam logic [2:0] CMD_WRITE_CUR = 3'd2;
  localparam logic [2:0] CMD_READ      = 3'd3;
  localparam logic [2:0] CMD_LOCATE    = 3'd4;
  localparam logic [2:0] CMD_FILL      = 3'd5;

  // Pixel modes; any other code sets the bit.
  localparam logic [1:0] DOT_CLEAR  = 2'b00;
  localparam logic [1:0] DOT_INVERT = 2'b11;

  // Memory operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_RMW,
    OP_READ,
    OP_FILL
  } op_kind_t;

  typedef enum logic [1:0] {
    RMW_CLEAR,
    RMW_INVERT,
    RMW_SET
  } rmw_mode_t;

  typedef struct packed {
    op_kind_t   kind;
    rmw_mode_t  mode;
    logic [7:0] mask;
    logic [7:0] data;
    logic       status;
  } op_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_FILL
  } bk_state_t;

  // Applies a pixel operation to one column byte.
  function automatic logic [7:0] apply_dot(rmw_mode_t mode, logic [7:0] old_byte,
                                           logic [7:0] mask);
    logic [7:0] res;
    res = old_byte | mask;
    if (mode == RMW_CLEAR) begin
      res = old_byte & ~mask;
    end else if (mode == RMW_INVERT) begin
      res = old_byte ^ mask;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/pmfb_front.sv
// Front end: range checks, address generation and the write cursor.
// Turns each accepted request into one memory operation; uses pmfb_pkg.
module pmfb_front import pmfb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF,
  localparam int ADDR_W = $clog2(COLUMNS * PAGES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [2:0]        command,
  input  logic [7:0]        x,
  input  logic [6:0]        y,
  input  logic signed [1:0] dot_mode,
  input  logic [7:0]        byte_value,
  output op_t               op,
  output logic [ADDR_W-1:0] op_addr
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ROWS   = PAGES * 8;

  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [PAGE_W-1:0] cur_page_r, cur_page_nxt;
  logic              coord_ok;
  logic [COL_W-1:0]  x_col;
  logic [PAGE_W-1:0] y_page;
  logic [ADDR_W-1:0] xy_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [7:0]        bit_mask;

  // Coordinate decode.
  assign coord_ok = ({1'b0, x} < 9'(COLUMNS)) && ({1'b0, y} < 8'(ROWS));
  assign x_col    = x[COL_W-1:0];
  assign y_page   = y[PAGE_W+2:3];
  assign xy_addr  = ADDR_W'(int'(y_page) * COLUMNS + int'(x_col));
  assign cur_addr = ADDR_W'(int'(cur_page_r) * COLUMNS + int'(cur_col_r));
  assign bit_mask = 8'(1) << y[2:0];

  // Classify the request and work out the cursor's next position.
  always_comb begin
    op           = '{kind: OP_NONE, mode: RMW_SET, mask: bit_mask,
                     data: byte_value, status: 1'b0};
    op_addr      = xy_addr;
    cur_col_nxt  = cur_col_r;
    cur_page_nxt = cur_page_r;
    unique case (command)
      CMD_PIXEL: begin
        if (coord_ok) begin
          op.kind = OP_RMW;
          if (dot_mode == DOT_CLEAR) begin
            op.mode = RMW_CLEAR;
          end else if (dot_mode == DOT_INVERT) begin
            op.mode = RMW_INVERT;
          end
        end else begin
          op.status = 1'b1;
        end
      end
      CMD_WRITE_XY: begin
        if (coord_ok) begin
          op.kind = OP_WRITE;
        end else begin
          op.status = 1'b1;
        end
      end
      CMD_WRITE_CUR: begin
        op.kind = OP_WRITE;
        op_addr = cur_addr;
        // Column wraps to the next page; the page sticks at the last one.
        if (cur_col_r == COL_W'(COLUMNS - 1)) begin
          cur_col_nxt = '0;
          if (cur_page_r != PAGE_W'(PAGES - 1)) begin
            cur_page_nxt = cur_page_r + 1'b1;
          end
        end else begin
          cur_col_nxt = cur_col_r + 1'b1;
        end
      end
      CMD_READ: begin
        if (coord_ok) begin
          op.kind = OP_READ;
        end else begin
          op.status = 1'b1;
        end
      end
      CMD_LOCATE: begin
        if (coord_ok) begin
          cur_col_nxt  = x_col;
          cur_page_nxt = y_page;
        end else begin
          op.status = 1'b1;
        end
      end
      CMD_FILL: begin
        op.kind = OP_FILL;
      end
      default: begin
      end
    endcase
  end

  // Cursor registers move only when a request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_page_r <= '0;
    end else if (accept) begin
      cur_col_r  <= cur_col_nxt;
      cur_page_r <= cur_page_nxt;
    end
  end

endmodule

FILE: hw/rtl/pmfb_queue.sv
// Small first-in first-out queue of memory operations.
// Sits between the front and back ends; uses pmfb_pkg for its depth.
module pmfb_queue import pmfb_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = slot_r[rd_ptr_r];

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/pmfb_back.sv
// Back end: display memory, read-modify-write and fill sequencer, result register.
// Takes operations from the queue; uses pmfb_pkg for types and the pixel helper.
module pmfb_back import pmfb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF,
  localparam int ADDR_W = $clog2(COLUMNS * PAGES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  op_t               q_op,
  input  logic [ADDR_W-1:0] q_addr,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_read_byte,
  output logic              out_status
);

  localparam int DEPTH = COLUMNS * PAGES;

  logic [7:0]        mem_r [DEPTH];
  logic [7:0]        rd_data_r;
  bk_state_t         state_r, state_nxt;
  op_t               cur_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              take_op;
  logic              rd_en;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              res_load;
  logic              load_ok;
  logic [7:0]        res_byte;
  logic              res_status;
  logic              out_valid_r;
  logic [7:0]        out_read_byte_r;
  logic              out_status_r;

  assign load_ok       = !out_valid_r || !out_stall;
  assign clearing      = (state_r == BK_CLEAR);
  assign out_valid     = out_valid_r;
  assign out_read_byte = out_read_byte_r;
  assign out_status    = out_status_r;

  // Sequencer: next state, memory controls and result load.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    q_pop      = 1'b0;
    take_op    = 1'b0;
    rd_en      = 1'b0;
    we         = 1'b0;
    waddr      = addr_r;
    wdata      = cur_r.data;
    res_load   = 1'b0;
    res_byte   = '0;
    res_status = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        // Sweep zeros through the whole memory after reset.
        we    = 1'b1;
        waddr = cnt_r;
        wdata = '0;
        if (cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = BK_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_op.kind)
            OP_WRITE: begin
              if (load_ok) begin
                q_pop    = 1'b1;
                we       = 1'b1;
                waddr    = q_addr;
                wdata    = q_op.data;
                res_load = 1'b1;
              end
            end
            OP_READ, OP_RMW: begin
              q_pop     = 1'b1;
              take_op   = 1'b1;
              rd_en     = 1'b1;
              state_nxt = BK_EXEC;
            end
            OP_FILL: begin
              q_pop     = 1'b1;
              take_op   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = BK_FILL;
            end
            default: begin
              if (load_ok) begin
                q_pop      = 1'b1;
                res_load   = 1'b1;
                res_status = q_op.status;
              end
            end
          endcase
        end
      end
      BK_EXEC: begin
        // Read data is back; finish the read or the pixel update.
        if (load_ok) begin
          res_load  = 1'b1;
          state_nxt = BK_IDLE;
          if (cur_r.kind == OP_RMW) begin
            we    = 1'b1;
            wdata = apply_dot(cur_r.mode, rd_data_r, cur_r.mask);
          end else begin
            res_byte = rd_data_r;
          end
        end
      end
      BK_FILL: begin
        // One byte of the pattern per cycle; the result follows the last one.
        we    = 1'b1;
        waddr = cnt_r;
        if (cnt_r == ADDR_W'(DEPTH - 1)) begin
          if (load_ok) begin
            res_load  = 1'b1;
            state_nxt = BK_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // State register and sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Operation held while it is being carried out.
  always_ff @(posedge clk) begin
    if (take_op) begin
      cur_r  <= q_op;
      addr_r <= q_addr;
    end
  end

  // Display memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[q_addr];
    end
  end

  // Result register parts the back end from the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_read_byte_r <= res_byte;
      out_status_r    <= res_status;
    end
  end

endmodule

FILE: hw/rtl/paged_mono_frame_buffer.sv
// Paged monochrome frame buffer: COLUMNS x (PAGES*8) pixels stored as PAGES
// pages of COLUMNS column bytes, bit b of a byte being pixel row page*8+b.
// Input channel (in_valid/in_stall) carries one command per request: pixel
// set, clear or invert, byte write at x and page, byte write at the cursor,
// byte read, cursor locate, or fill. Result channel (out_valid/out_stall)
// returns one result per request, in order: the byte read and a status bit.
// Each request passes through the queue and the result register; reads and
// pixel operations also take a memory read in the back end before the result
// or the write back, and a fill writes one byte a cycle through the memory.
// The back end takes a new request from the queue only when it is done with
// the last one; a fill holds it until every byte is written.
// A two-entry queue lets the front end keep taking requests while the back
// end is busy or the result register is held by out_stall.
// After reset the memory is cleared by a pass that writes zero to each of the
// COLUMNS*PAGES bytes (1024 by default), during which in_stall stays high.
// Dependencies: pmfb_pkg, pmfb_front, pmfb_queue, pmfb_back.
module paged_mono_frame_buffer import pmfb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_command,
  input  logic [7:0]        in_x,
  input  logic [6:0]        in_y,
  input  logic signed [1:0] in_dot_mode,
  input  logic [7:0]        in_byte_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_read_byte,
  output logic              out_status
);

  localparam int ADDR_W  = $clog2(COLUMNS * PAGES);
  localparam int ENTRY_W = $bits(op_t) + ADDR_W;

  logic              accept;
  op_t               front_op;
  logic [ADDR_W-1:0] front_addr;
  logic [ENTRY_W-1:0] head_entry;
  op_t               head_op;
  logic [ADDR_W-1:0] head_addr;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic              clearing;

  // Requests are refused while the queue is full or the memory is being cleared.
  assign in_stall = q_full || clearing;
  assign accept   = in_valid && !in_stall;

  pmfb_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .x          (in_x),
    .y          (in_y),
    .dot_mode   (in_dot_mode),
    .byte_value (in_byte_value),
    .op         (front_op),
    .op_addr    (front_addr)
  );

  pmfb_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data ({front_op, front_addr}),
    .pop       (q_pop),
    .head_data (head_entry),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign head_op   = op_t'(head_entry[ENTRY_W-1:ADDR_W]);
  assign head_addr = head_entry[ADDR_W-1:0];

  pmfb_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_op          (head_op),
    .q_addr        (head_addr),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_byte (out_read_byte),
    .out_status    (out_status)
  );

endmodule

FILE: hw/rtl/pmfb_checker.sv
// Port-level checks for the paged monochrome frame buffer.
// Bound to paged_mono_frame_buffer; depends only on its ports.
module pmfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_byte,
  input logic       out_status
);

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_byte) && $stable(out_status))
    else $error("result changed while stalled");

  // The clearing pass blocks requests straight after reset.
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("request channel open during memory clear");

  // No result is shown when reset is released.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result present straight after reset");

  // A rejected request never returns data.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_byte == 8'd0)
    else $error("out-of-range result carries data");

endmodule

bind paged_mono_frame_buffer pmfb_checker u_pmfb_checker (.*);

FILE: test/pmfb_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the paged monochrome frame buffer. It keeps its own copy of the
// display memory and cursor, predicts each accepted request and checks results.
// Depends on pmfb_pkg for the command and pixel-mode codes.
module pmfb_frame_checker import pmfb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        in_command,
  input  logic [7:0]        in_x,
  input  logic [6:0]        in_y,
  input  logic signed [1:0] in_dot_mode,
  input  logic [7:0]        in_byte_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_read_byte,
  input  logic              out_status,
  output int                fail_count,
  output int                pending_results,
  output int                results_checked,
  output int                rejects_seen,
  output int                fills_seen,
  output int                cursor_wraps
);

  localparam int COLS       = COLUMNS_DEF;
  localparam int PAGE_COUNT = PAGES_DEF;
  localparam int ROWS       = PAGE_COUNT * 8;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       status;
  } frame_result_t;

  logic [7:0]    frame_image [COLS * PAGE_COUNT];
  int unsigned   cursor_col;
  int unsigned   cursor_pg;
  frame_result_t expected_q [$];
  frame_result_t prediction;
  frame_result_t oldest;

  // Applies one command to the mirrored memory and cursor, returning its result.
  function automatic frame_result_t apply_command(logic [2:0] cmd, logic [7:0] x,
                                                  logic [6:0] y, logic [1:0] dot,
                                                  logic [7:0] value);
    frame_result_t res;
    logic          hit;
    int            addr;
    logic [7:0]    mask;
    res  = '0;
    hit  = (x < COLS) && (y < ROWS);
    addr = int'(y[6:3]) * COLS + int'(x);
    mask = 8'd1 << y[2:0];
    case (cmd)
      CMD_PIXEL: begin
        if (!hit) begin
          res.status = 1'b1;
        end else if (dot == DOT_CLEAR) begin
          frame_image[addr] = frame_image[addr] & ~mask;
        end else if (dot == DOT_INVERT) begin
          frame_image[addr] = frame_image[addr] ^ mask;
        end else begin
          frame_image[addr] = frame_image[addr] | mask;
        end
      end
      CMD_WRITE_XY: begin
        if (!hit) begin
          res.status = 1'b1;
        end else begin
          frame_image[addr] = value;
        end
      end
      CMD_WRITE_CUR: begin
        // The column wraps onto the next page; the page sticks at the last one.
        frame_image[cursor_pg * COLS + cursor_col] = value;
        cursor_col++;
        if (cursor_col >= COLS) begin
          cursor_col = 0;
          cursor_wraps++;
          cursor_pg = (cursor_pg + 1 < PAGE_COUNT) ? cursor_pg + 1 : PAGE_COUNT - 1;
        end
      end
      CMD_READ: begin
        if (!hit) begin
          res.status = 1'b1;
        end else begin
          res.read_byte = frame_image[addr];
        end
      end
      CMD_LOCATE: begin
        if (!hit) begin
          res.status = 1'b1;
        end else begin
          cursor_col = x;
          cursor_pg  = y[6:3];
        end
      end
      CMD_FILL: begin
        foreach (frame_image[i]) begin
          frame_image[i] = value;
        end
        fills_seen++;
      end
      default: begin
        // Spare command codes are accepted and do nothing.
      end
    endcase
    return res;
  endfunction

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (frame_image[i]) begin
        frame_image[i] = 8'h00;
      end
      cursor_col      = 0;
      cursor_pg       = 0;
      results_checked = 0;
      rejects_seen    = 0;
      fills_seen      = 0;
      cursor_wraps    = 0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        prediction = apply_command(in_command, in_x, in_y, in_dot_mode, in_byte_value);
        if (prediction.status) begin
          rejects_seen++;
        end
        expected_q.push_back(prediction);
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("Result with no request outstanding: read_byte %0h, status %0d",
                 out_read_byte, out_status);
          fail_count++;
        end else begin
          oldest = expected_q.pop_front();
          results_checked++;
          if (out_read_byte !== oldest.read_byte) begin
            $error("read_byte mismatch: expected %02h, got %02h",
                   oldest.read_byte, out_read_byte);
            fail_count++;
          end
          if (out_status !== oldest.status) begin
            $error("status mismatch: expected %0d, got %0d", oldest.status, out_status);
            fail_count++;
          end
        end
      end
    end
    pending_results = expected_q.size();
  end

endmodule

FILE: test/paged_mono_frame_buffer_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for paged_mono_frame_buffer: drives directed and random
// requests under several handshake patterns and gives the verdict.
// Depends on pmfb_pkg, the frame buffer RTL and pmfb_frame_checker.
module paged_mono_frame_buffer_tb;
  import pmfb_pkg::*;

  // Spare command codes and the pixel modes that set the bit.
  localparam logic [2:0] CMD_SPARE_6    = 3'd6;
  localparam logic [2:0] CMD_SPARE_7    = 3'd7;
  localparam logic [1:0] DOT_SET        = 2'b01;
  localparam logic [1:0] DOT_MINUS_TWO  = 2'b10;

  localparam int RANDOM_REQUESTS = 1300;
  localparam int HOLD_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT  = 8000;

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [2:0]        in_command    = CMD_READ;
  logic [7:0]        in_x          = 8'd0;
  logic [6:0]        in_y          = 7'd0;
  logic signed [1:0] in_dot_mode   = 2'sb00;
  logic [7:0]        in_byte_value = 8'd0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [7:0]        out_read_byte;
  logic              out_status;

  int fail_count;
  int pending_results;
  int results_checked;
  int rejects_seen;
  int fills_seen;
  int cursor_wraps;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int requests_sent = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  paged_mono_frame_buffer u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_dot_mode   (in_dot_mode),
    .in_byte_value (in_byte_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_byte (out_read_byte),
    .out_status    (out_status)
  );

  pmfb_frame_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_dot_mode     (in_dot_mode),
    .in_byte_value   (in_byte_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_byte   (out_read_byte),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .rejects_seen    (rejects_seen),
    .fills_seen      (fills_seen),
    .cursor_wraps    (cursor_wraps)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: a long hold-off when asked for, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: ends the run when no request or result moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("paged_mono_frame_buffer_tb NOT OK");
      $finish;
    end
  end

  // Offers one request, waits for it to be taken, then idles at random.
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] x,
                              input logic [6:0] y, input logic [1:0] dot,
                              input logic [7:0] value);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_x          <= x;
    in_y          <= y;
    in_dot_mode   <= dot;
    in_byte_value <= value;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    requests_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stops offering requests until every expected result has come back.
  // The count is read away from the rising edge, once the scoreboard has
  // settled, and driving picks up again on the next rising edge.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    @(negedge clk);
    while (pending_results != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // One random request; coordinates lean towards a few busy corners so that
  // reads and pixel operations meet bytes written earlier.
  task automatic send_random_request();
    int         pick;
    int         where;
    logic [2:0] cmd;
    logic [7:0] x;
    logic [6:0] y;
    pick = $urandom_range(999);
    if (pick < 10) begin
      cmd = CMD_FILL;
    end else if (pick < 20) begin
      cmd = CMD_SPARE_6;
    end else if (pick < 30) begin
      cmd = CMD_SPARE_7;
    end else if (pick < 300) begin
      cmd = CMD_PIXEL;
    end else if (pick < 450) begin
      cmd = CMD_WRITE_XY;
    end else if (pick < 600) begin
      cmd = CMD_WRITE_CUR;
    end else if (pick < 900) begin
      cmd = CMD_READ;
    end else begin
      cmd = CMD_LOCATE;
    end
    where = $urandom_range(99);
    if (where < 45) begin
      x = 8'($urandom_range(3) + ($urandom_range(1) ? 124 : 0));
      y = 7'($urandom_range(15) + ($urandom_range(1) ? 48 : 0));
    end else if (where < 85) begin
      x = 8'($urandom_range(127));
      y = 7'($urandom_range(63));
    end else if (where < 92) begin
      x = 8'($urandom_range(255, 128));
      y = 7'($urandom_range(127));
    end else if (where < 97) begin
      x = 8'($urandom_range(127));
      y = 7'($urandom_range(127, 64));
    end else begin
      x = 8'($urandom_range(255));
      y = 7'($urandom_range(127));
    end
    send_request(cmd, x, y, 2'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  // Places the cursor near the end of a line and writes a run of bytes that can
  // cross the wrap, often on the last page so that the page clamp is exercised.
  task automatic send_cursor_run();
    int run_length;
    run_length = $urandom_range(48, 4);
    send_request(CMD_LOCATE, 8'($urandom_range(127, 96)),
                 7'($urandom_range(1) ? $urandom_range(63, 56) : $urandom_range(63)),
                 2'($urandom_range(3)), 8'($urandom_range(255)));
    repeat (run_length) begin
      send_request(CMD_WRITE_CUR, 8'($urandom_range(255)), 7'($urandom_range(127)),
                   2'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int phase_goal;
    bit held;
    held = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: corners, every command, rejects, cursor wrap and clamp.
    send_request(CMD_READ,      8'd0,   7'd0,   DOT_SET,       8'h00);
    send_request(CMD_PIXEL,     8'd0,   7'd0,   DOT_SET,       8'h00);
    send_request(CMD_PIXEL,     8'd127, 7'd63,  DOT_MINUS_TWO, 8'hFF);
    send_request(CMD_READ,      8'd127, 7'd63,  DOT_SET,       8'h00);
    send_request(CMD_PIXEL,     8'd127, 7'd63,  DOT_INVERT,    8'h00);
    send_request(CMD_WRITE_XY,  8'd127, 7'd63,  DOT_CLEAR,     8'hFF);
    send_request(CMD_WRITE_XY,  8'd0,   7'd0,   DOT_CLEAR,     8'hA5);
    send_request(CMD_PIXEL,     8'd0,   7'd0,   DOT_CLEAR,     8'h00);
    send_request(CMD_READ,      8'd127, 7'd63,  DOT_SET,       8'h00);
    send_request(CMD_PIXEL,     8'd128, 7'd0,   DOT_SET,       8'h00);
    send_request(CMD_WRITE_XY,  8'd0,   7'd64,  DOT_SET,       8'h3C);
    send_request(CMD_READ,      8'd255, 7'd127, DOT_SET,       8'h00);
    send_request(CMD_LOCATE,    8'd200, 7'd10,  DOT_SET,       8'h00);
    send_request(CMD_LOCATE,    8'd126, 7'd63,  DOT_SET,       8'h00);
    send_request(CMD_WRITE_CUR, 8'd0,   7'd0,   DOT_SET,       8'h11);
    send_request(CMD_WRITE_CUR, 8'd0,   7'd0,   DOT_SET,       8'h22);
    send_request(CMD_WRITE_CUR, 8'd0,   7'd0,   DOT_SET,       8'h33);
    send_request(CMD_READ,      8'd0,   7'd56,  DOT_SET,       8'h00);
    send_request(CMD_LOCATE,    8'd127, 7'd0,   DOT_SET,       8'h00);
    send_request(CMD_WRITE_CUR, 8'd0,   7'd0,   DOT_SET,       8'h55);
    send_request(CMD_WRITE_CUR, 8'd0,   7'd0,   DOT_SET,       8'h66);
    send_request(CMD_READ,      8'd0,   7'd8,   DOT_SET,       8'h00);
    send_request(CMD_SPARE_6,   8'd5,   7'd5,   DOT_SET,       8'hFF);
    send_request(CMD_SPARE_7,   8'd5,   7'd5,   DOT_SET,       8'hFF);
    send_request(CMD_FILL,      8'd0,   7'd0,   DOT_SET,       8'h5A);
    send_request(CMD_READ,      8'd64,  7'd32,  DOT_SET,       8'h00);
    wait_for_drain();

    // Random requests in four handshake phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 59;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 59;
        end
        default: begin
          send_idle_pct = 15;
          stall_pct    <= 15;
        end
      endcase
      phase_goal = requests_sent + RANDOM_REQUESTS / 4;
      while (requests_sent < phase_goal) begin
        if (phase == 0 && !held && requests_sent + 200 >= phase_goal) begin
          // Long receiver hold-off while requests keep coming, then a full drain.
          held = 1'b1;
          hold_requests <= hold_requests + 1;
          repeat (30) begin
            send_random_request();
          end
          wait_for_drain();
        end else if ($urandom_range(99) < 3) begin
          send_cursor_run();
        end else begin
          send_random_request();
        end
      end
      wait_for_drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d requests and checked %0d results: %0d rejected coordinates,",
             requests_sent, results_checked, rejects_seen);
    $display("%0d fills and %0d cursor line wraps, under four handshake patterns.",
             fills_seen, cursor_wraps);
    if (fail_count == 0) begin
      $display("paged_mono_frame_buffer_tb OK");
    end else begin
      $display("paged_mono_frame_buffer_tb NOT OK");
    end
    $finish;
  end

endmodule
